>>> rtl/core/arme_pkg.sv
// ----------------------------------------------------------------------------
// arme_pkg: shared definitions of the accumulator machine execute core
// Sizes, operation and error codes, controller states and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package arme_pkg;

    // Machine sizes.
    localparam int NUM_REGS   = 16;
    localparam int PROG_DEPTH = 4096;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int WORD_W     = 32;
    localparam int TGT_W      = 12;

    // Operation codes carried by the action field.
    typedef enum logic [3:0] {
        ACT_LOAD_IMM = 4'd0,
        ACT_LOAD_DIR = 4'd1,
        ACT_STORE    = 4'd2,
        ACT_ADD      = 4'd3,
        ACT_SUB      = 4'd4,
        ACT_MUL      = 4'd5,
        ACT_DIV      = 4'd6,
        ACT_READ     = 4'd7,
        ACT_WRITE    = 4'd8,
        ACT_JUMP     = 4'd9,
        ACT_JZERO    = 4'd10,
        ACT_JGTZ     = 4'd11
    } act_t;

    // Error codes of a result.
    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_LABEL = 2'd1,
        ERR_DIV0  = 2'd2,
        ERR_INDEX = 2'd3
    } err_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_DIV  = 2'd2,
        ST_OUT  = 2'd3
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the accepted request
        logic exec;        // execute the held instruction
        logic div_commit;  // write the quotient to the accumulator
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_needed;  // held instruction divides by a non-zero value
        logic div_done;    // quotient is ready
    } dp_status_t;

endpackage

>>> rtl/core/arme_divider.sv
// ----------------------------------------------------------------------------
// arme_divider: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, with the
// sign applied in a final cycle. Truncates toward zero and wraps on overflow.
// ----------------------------------------------------------------------------
module arme_divider
    import arme_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WORD_W:0]   trial;

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign trial = {rem_reg, quo_reg[WORD_W-1]} - {1'b0, dvs_reg};

    // Iteration control and datapath next values.
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        res_next  = res_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend[WORD_W-1] ? (-dividend) : dividend;
            dvs_next  = divisor[WORD_W-1] ? (-divisor) : divisor;
            neg_next  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
            rem_next  = '0;
            cnt_next  = CNT_W'(WORD_W);
            busy_next = 1'b1;
        end else if (busy_reg && (cnt_reg != '0)) begin
            if (!trial[WORD_W]) begin
                rem_next = trial[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]};
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end else if (busy_reg) begin
            res_next  = neg_reg ? (-quo_reg) : quo_reg;
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        res_reg <= res_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = res_reg;

endmodule

>>> rtl/core/arme_datapath.sv
// ----------------------------------------------------------------------------
// arme_datapath: register file, instruction execution and result registers
// Holds the accepted request, executes it (or hands a division to the
// iterative divider) and keeps the result fields until delivered.
// ----------------------------------------------------------------------------
module arme_datapath
    import arme_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ctrl_cmd_t                cmd,
    output dp_status_t               status,
    input  logic [3:0]               in_action,
    input  logic signed [WORD_W-1:0] in_operand,
    input  logic [TGT_W-1:0]         in_jump_target,
    input  logic                     in_label_found,
    input  logic signed [WORD_W-1:0] in_tape_value,
    output logic                     out_jump_taken,
    output logic [TGT_W-1:0]         out_target,
    output logic                     out_write_valid,
    output logic signed [WORD_W-1:0] out_write_value,
    output logic [1:0]               out_error_code
);

    // Held request.
    logic [3:0]        act_reg;
    logic [WORD_W-1:0] op_reg;
    logic [TGT_W-1:0]  tgt_reg;
    logic              found_reg;
    logic [WORD_W-1:0] tape_reg;

    // Register file; entry zero is the accumulator.
    logic [WORD_W-1:0] rf_reg [NUM_REGS];

    // Result registers.
    logic              jump_reg, jump_next;
    logic [TGT_W-1:0]  tout_reg, tout_next;
    logic              wvalid_reg, wvalid_next;
    logic [WORD_W-1:0] wval_reg, wval_next;
    logic [1:0]        err_reg, err_next;

    logic                 idx_ok;
    logic [REG_IDX_W-1:0] idx;
    logic [WORD_W-1:0]    acc;
    logic [WORD_W-1:0]    rd_data;
    logic [WORD_W-1:0]    mul_lo;
    logic                 want_jump;
    logic                 label_ok;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] wr_idx;
    logic [WORD_W-1:0]    wr_data;
    logic                 div_start;
    logic                 div_done;
    logic [WORD_W-1:0]    div_quo;

    assign idx_ok   = (op_reg < WORD_W'(NUM_REGS));
    assign idx      = op_reg[REG_IDX_W-1:0];
    assign acc      = rf_reg[0];
    assign rd_data  = rf_reg[idx];
    assign mul_lo   = acc * op_reg;
    assign label_ok = found_reg && (WORD_W'(tgt_reg) < WORD_W'(PROG_DEPTH));

    // Instruction decode and execution.
    always_comb begin
        wr_en       = 1'b0;
        wr_idx      = '0;
        wr_data     = '0;
        want_jump   = 1'b0;
        wvalid_next = 1'b0;
        wval_next   = '0;
        err_next    = ERR_OK;
        case (act_t'(act_reg))
            ACT_LOAD_IMM: begin
                wr_en   = 1'b1;
                wr_data = op_reg;
            end
            ACT_LOAD_DIR: begin
                if (idx_ok) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                end else begin
                    err_next = ERR_INDEX;
                end
            end
            ACT_STORE: begin
                if (idx_ok) begin
                    wr_en   = 1'b1;
                    wr_idx  = idx;
                    wr_data = acc;
                end else begin
                    err_next = ERR_INDEX;
                end
            end
            ACT_ADD: begin
                wr_en   = 1'b1;
                wr_data = acc + op_reg;
            end
            ACT_SUB: begin
                wr_en   = 1'b1;
                wr_data = acc - op_reg;
            end
            ACT_MUL: begin
                wr_en   = 1'b1;
                wr_data = mul_lo;
            end
            ACT_DIV: begin
                // A non-zero divisor goes to the divider instead.
                if (op_reg == '0) begin
                    err_next = ERR_DIV0;
                end
            end
            ACT_READ: begin
                if (idx_ok) begin
                    wr_en   = 1'b1;
                    wr_idx  = idx;
                    wr_data = tape_reg;
                end else begin
                    err_next = ERR_INDEX;
                end
            end
            ACT_WRITE: begin
                if (idx_ok) begin
                    wvalid_next = 1'b1;
                    wval_next   = rd_data;
                end else begin
                    err_next = ERR_INDEX;
                end
            end
            ACT_JUMP: begin
                want_jump = 1'b1;
            end
            ACT_JZERO: begin
                want_jump = (acc == '0);
            end
            ACT_JGTZ: begin
                want_jump = (acc != '0) && !acc[WORD_W-1];
            end
            default: begin
            end
        endcase
        jump_next = 1'b0;
        tout_next = '0;
        if (want_jump) begin
            if (label_ok) begin
                jump_next = 1'b1;
                tout_next = tgt_reg;
            end else begin
                err_next = ERR_LABEL;
            end
        end
    end

    assign status.div_needed = (act_t'(act_reg) == ACT_DIV) && (op_reg != '0);
    assign status.div_done   = div_done;
    assign div_start         = cmd.exec && status.div_needed;

    arme_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc),
        .divisor  (op_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Register file, cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                rf_reg[i] <= '0;
            end
        end else if (cmd.div_commit) begin
            rf_reg[0] <= div_quo;
        end else if (cmd.exec && wr_en) begin
            rf_reg[wr_idx] <= wr_data;
        end
    end

    // Held request and result fields.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg   <= in_action;
            op_reg    <= in_operand;
            tgt_reg   <= in_jump_target;
            found_reg <= in_label_found;
            tape_reg  <= in_tape_value;
        end
        if (cmd.exec) begin
            jump_reg   <= jump_next;
            tout_reg   <= tout_next;
            wvalid_reg <= wvalid_next;
            wval_reg   <= wval_next;
            err_reg    <= err_next;
        end
    end

    assign out_jump_taken  = jump_reg;
    assign out_target      = tout_reg;
    assign out_write_valid = wvalid_reg;
    assign out_write_value = wval_reg;
    assign out_error_code  = err_reg;

endmodule

>>> rtl/core/arme_ctrl.sv
// ----------------------------------------------------------------------------
// arme_ctrl: instruction sequencer
// Accepts one request, steps the datapath through execution and an optional
// division, then offers the result until it is taken.
// ----------------------------------------------------------------------------
module arme_ctrl
    import arme_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output ctrl_cmd_t  cmd,
    input  dp_status_t status
);

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        m_valid        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = status.div_needed ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                if (status.div_done) begin
                    cmd.div_commit = 1'b1;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // A new request is never taken while a result is on offer.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request accepted while a result is pending");

    // An accepted request is executed in the following cycle.
    a_exec_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> cmd.exec)
        else $error("accepted request not executed");

    // A finished division leads straight to the result.
    a_div_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && status.div_done) |=> m_valid)
        else $error("division result not offered");
`endif

endmodule

>>> rtl/core/accumulator_ram_machine_execute_core.sv
// ----------------------------------------------------------------------------
// accumulator_ram_machine_execute_core: one-instruction execute unit
// Executes accumulator machine instructions against a cleared-at-reset
// register file and reports jump decision, tape write and error code.
//
//   Channel   Direction  Ports                                  Moves
//   s_        in         action, operand, jump_target,          one request
//                        label_found, tape_value
//   m_        out        jump_taken, target_out, write_valid,   one result
//                        write_value, error_code
//
// The result is registered in the execute state and offered in the offer
// state, so a request that is taken at once passes through accept, execute
// and offer. A division by a non-zero value adds a divide state: 32 quotient-bit
// steps of the iterative divider, a sign step and the accumulator write.
// One request is in flight at a time; the next is taken once the result is
// accepted. Reset clears every register of the file and idles the unit;
// a stalled result is held unchanged.
// ----------------------------------------------------------------------------
module accumulator_ram_machine_execute_core
    import arme_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [3:0]               s_action,
    input  logic signed [WORD_W-1:0] s_operand,
    input  logic [TGT_W-1:0]         s_jump_target,
    input  logic                     s_label_found,
    input  logic signed [WORD_W-1:0] s_tape_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_jump_taken,
    output logic [TGT_W-1:0]         m_target_out,
    output logic                     m_write_valid,
    output logic signed [WORD_W-1:0] m_write_value,
    output logic [1:0]               m_error_code
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer.
    arme_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // Register file and execution.
    arme_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .in_action       (s_action),
        .in_operand      (s_operand),
        .in_jump_target  (s_jump_target),
        .in_label_found  (s_label_found),
        .in_tape_value   (s_tape_value),
        .out_jump_taken  (m_jump_taken),
        .out_target      (m_target_out),
        .out_write_valid (m_write_valid),
        .out_write_value (m_write_value),
        .out_error_code  (m_error_code)
    );

endmodule

>>> bench/execute_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// execute_checker: result scoreboard for the accumulator machine execute core
// Watches both channels of the core. Each accepted request is executed
// against a private copy of the register file to work out the result it
// must give, and each accepted result is compared field by field with the
// oldest one still waiting.
// ----------------------------------------------------------------------------
module execute_checker
    import arme_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [3:0]        s_action,
    input  logic [WORD_W-1:0] s_operand,
    input  logic [TGT_W-1:0]  s_jump_target,
    input  logic              s_label_found,
    input  logic [WORD_W-1:0] s_tape_value,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_jump_taken,
    input  logic [TGT_W-1:0]  m_target_out,
    input  logic              m_write_valid,
    input  logic [WORD_W-1:0] m_write_value,
    input  logic [1:0]        m_error_code,
    input  logic              end_of_test,
    output int                outstanding,
    output int                mismatches
);

    localparam int REPORT_LIMIT = 10;

    // One result as it leaves the core.
    typedef struct packed {
        logic              jump_taken;
        logic [TGT_W-1:0]  target;
        logic              write_valid;
        logic [WORD_W-1:0] write_value;
        err_t              code;
    } outcome_t;

    logic [WORD_W-1:0] reg_file [NUM_REGS];
    outcome_t          pending_outcomes [$];
    int                results_seen;
    logic              leftovers_counted;

    initial begin
        outstanding = 0;
        mismatches = 0;
        results_seen = 0;
        leftovers_counted = 1'b0;
    end

    // Executes one instruction on the private register file and returns the
    // result that the core has to report for it.
    function automatic outcome_t execute_instruction(
        input logic [3:0]        action,
        input logic [WORD_W-1:0] operand,
        input logic [TGT_W-1:0]  target,
        input logic              found,
        input logic [WORD_W-1:0] tape
    );
        outcome_t          res;
        logic [WORD_W-1:0] acc;
        logic [WORD_W-1:0] num_mag;
        logic [WORD_W-1:0] den_mag;
        logic [WORD_W-1:0] quo;
        logic              index_valid;
        logic              branch;
        res = '0;
        res.code = ERR_OK;
        acc = reg_file[0];
        // A negative index reads as a huge unsigned value and so fails too.
        index_valid = (operand < WORD_W'(NUM_REGS));
        branch = 1'b0;
        case (action)
            ACT_LOAD_IMM: reg_file[0] = operand;
            ACT_LOAD_DIR: begin
                if (index_valid) reg_file[0] = reg_file[operand[REG_IDX_W-1:0]];
                else res.code = ERR_INDEX;
            end
            ACT_STORE: begin
                if (index_valid) reg_file[operand[REG_IDX_W-1:0]] = acc;
                else res.code = ERR_INDEX;
            end
            ACT_ADD: reg_file[0] = acc + operand;
            ACT_SUB: reg_file[0] = acc - operand;
            ACT_MUL: reg_file[0] = acc * operand;
            ACT_DIV: begin
                // Divide magnitudes, then restore the sign: this truncates
                // toward zero and lets the most negative value wrap.
                if (operand == '0) begin
                    res.code = ERR_DIV0;
                end else begin
                    num_mag = acc[WORD_W-1] ? -acc : acc;
                    den_mag = operand[WORD_W-1] ? -operand : operand;
                    quo = num_mag / den_mag;
                    reg_file[0] = (acc[WORD_W-1] ^ operand[WORD_W-1]) ? -quo : quo;
                end
            end
            ACT_READ: begin
                if (index_valid) reg_file[operand[REG_IDX_W-1:0]] = tape;
                else res.code = ERR_INDEX;
            end
            ACT_WRITE: begin
                if (index_valid) begin
                    res.write_valid = 1'b1;
                    res.write_value = reg_file[operand[REG_IDX_W-1:0]];
                end else begin
                    res.code = ERR_INDEX;
                end
            end
            ACT_JUMP:  branch = 1'b1;
            ACT_JZERO: branch = (acc == '0);
            ACT_JGTZ:  branch = (acc != '0) && !acc[WORD_W-1];
            default: ;
        endcase
        // The label is only looked at when the branch would be taken.
        if (branch) begin
            if (found && (int'(target) < PROG_DEPTH)) begin
                res.jump_taken = 1'b1;
                res.target = target;
            end else begin
                res.code = ERR_LABEL;
            end
        end
        return res;
    endfunction

    function automatic void note_failure(input string msg);
        if (mismatches < REPORT_LIMIT) $display("%s", msg);
        mismatches++;
    endfunction

    // Result check first, then prediction of the newly accepted request.
    always @(posedge aclk) begin
        outcome_t got;
        outcome_t exp;
        if (!aresetn) begin
            foreach (reg_file[i]) reg_file[i] = '0;
            pending_outcomes.delete();
        end else begin
            if (m_valid && m_ready) begin
                got.jump_taken = m_jump_taken;
                got.target = m_target_out;
                got.write_valid = m_write_valid;
                got.write_value = m_write_value;
                got.code = err_t'(m_error_code);
                if (pending_outcomes.size() == 0) begin
                    note_failure($sformatf(
                        "result %0d arrived with no request waiting: jump %0b target %0d write %0b %h error %0d",
                        results_seen, got.jump_taken, got.target, got.write_valid,
                        got.write_value, got.code));
                end else begin
                    exp = pending_outcomes.pop_front();
                    if (got.jump_taken !== exp.jump_taken || got.target !== exp.target ||
                        got.write_valid !== exp.write_valid ||
                        got.write_value !== exp.write_value || got.code !== exp.code) begin
                        note_failure($sformatf(
                            {"result %0d: expected jump %0b target %0d write %0b %h error %0d,",
                             " got jump %0b target %0d write %0b %h error %0d"},
                            results_seen, exp.jump_taken, exp.target, exp.write_valid,
                            exp.write_value, exp.code, got.jump_taken, got.target,
                            got.write_valid, got.write_value, got.code));
                    end
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                pending_outcomes.push_back(execute_instruction(s_action, s_operand,
                    s_jump_target, s_label_found, s_tape_value));
            end
            // Anything still waiting at the end of the run never arrived.
            if (end_of_test && !leftovers_counted) begin
                leftovers_counted = 1'b1;
                while (pending_outcomes.size() > 0) begin
                    exp = pending_outcomes.pop_front();
                    note_failure($sformatf(
                        "expected result never arrived: jump %0b target %0d write %0b %h error %0d",
                        exp.jump_taken, exp.target, exp.write_valid, exp.write_value,
                        exp.code));
                end
            end
        end
        outstanding = pending_outcomes.size();
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the accumulator machine execute core
// Drives a directed set of instructions covering every operation and the
// error cases, then several hundred random instructions with random gaps on
// both channels, one long result stall and a drain mid-run. The checker
// beside the core does all prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;
    import arme_pkg::*;

    localparam int          RANDOM_REQUESTS = 800;
    localparam int          LONG_HOLD       = 300;
    localparam int          DRAIN_CYCLES    = 40;
    localparam int          CYCLE_LIMIT     = 400000;
    localparam logic [3:0]  ACT_SPARE_LO    = 4'd12;
    localparam logic [3:0]  ACT_SPARE_HI    = 4'd15;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [3:0]        s_action;
    logic [WORD_W-1:0] s_operand;
    logic [TGT_W-1:0]  s_jump_target;
    logic              s_label_found;
    logic [WORD_W-1:0] s_tape_value;
    logic              m_valid;
    logic              m_ready;
    logic              m_jump_taken;
    logic [TGT_W-1:0]  m_target_out;
    logic              m_write_valid;
    logic [WORD_W-1:0] m_write_value;
    logic [1:0]        m_error_code;
    logic              end_of_test;
    int                outstanding;
    int                mismatches;
    int                hold_requests = 0;
    logic              calm_phase = 1'b0;
    int                cycle_count = 0;

    always #1 aclk = ~aclk;

    accumulator_ram_machine_execute_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_operand     (s_operand),
        .s_jump_target (s_jump_target),
        .s_label_found (s_label_found),
        .s_tape_value  (s_tape_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_jump_taken  (m_jump_taken),
        .m_target_out  (m_target_out),
        .m_write_valid (m_write_valid),
        .m_write_value (m_write_value),
        .m_error_code  (m_error_code)
    );

    execute_checker scoreboard (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_operand     (s_operand),
        .s_jump_target (s_jump_target),
        .s_label_found (s_label_found),
        .s_tape_value  (s_tape_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_jump_taken  (m_jump_taken),
        .m_target_out  (m_target_out),
        .m_write_valid (m_write_valid),
        .m_write_value (m_write_value),
        .m_error_code  (m_error_code),
        .end_of_test   (end_of_test),
        .outstanding   (outstanding),
        .mismatches    (mismatches)
    );

    // Gap length in cycles: mostly none or short, now and then long.
    function automatic int idle_length();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // A data word biased towards the values where arithmetic goes wrong.
    function automatic logic [WORD_W-1:0] pick_word();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            case ($urandom_range(0, 4))
                0:       return 32'h0000_0000;
                1:       return 32'h0000_0001;
                2:       return 32'hffff_ffff;
                3:       return 32'h7fff_ffff;
                default: return 32'h8000_0000;
            endcase
        end
        if (sel < 40) return WORD_W'($urandom_range(0, 16)) - 32'd8;
        return $urandom;
    endfunction

    // Offers one request and returns once it has been accepted.
    task automatic issue(
        input logic [3:0]        action,
        input logic [WORD_W-1:0] operand,
        input logic [TGT_W-1:0]  target,
        input logic              found,
        input logic [WORD_W-1:0] tape
    );
        @(negedge aclk);
        s_action <= action;
        s_operand <= operand;
        s_jump_target <= target;
        s_label_found <= found;
        s_tape_value <= tape;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Withdraws the request channel for the given number of cycles.
    task automatic sender_gap(input int cycles);
        if (cycles > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (cycles - 1) @(negedge aclk);
        end
    endtask

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is asked.
    initial begin : result_receiver
        int stall_left;
        int holds_served;
        stall_left = 0;
        holds_served = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !calm_phase && $urandom_range(0, 3) == 0) begin
                stall_left = idle_length();
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Request side and verdict.
    initial begin : request_sender
        logic [3:0]        act;
        logic [WORD_W-1:0] operand;
        s_valid = 1'b0;
        s_action = '0;
        s_operand = '0;
        s_jump_target = '0;
        s_label_found = 1'b0;
        s_tape_value = '0;
        end_of_test = 1'b0;
        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Branches on a zero accumulator, with and without a label.
        issue(ACT_LOAD_IMM, 32'h0000_0000, 12'h000, 1'b1, 32'h0000_0000);
        issue(ACT_JZERO,    32'h0000_0000, 12'h000, 1'b1, 32'h0000_0000);
        issue(ACT_JZERO,    32'hffff_ffff, 12'hfff, 1'b0, 32'hffff_ffff);
        issue(ACT_JGTZ,     32'h0000_0000, 12'h555, 1'b0, 32'h0000_0000);
        // Wrapping add, most negative divided by minus one, wrapping sub.
        issue(ACT_LOAD_IMM, 32'h7fff_ffff, 12'h000, 1'b1, 32'h0000_0000);
        issue(ACT_ADD,      32'h0000_0001, 12'h000, 1'b1, 32'h0000_0000);
        issue(ACT_JGTZ,     32'h0000_0000, 12'hfff, 1'b1, 32'h0000_0000);
        issue(ACT_DIV,      32'hffff_ffff, 12'h000, 1'b1, 32'h0000_0000);
        issue(ACT_STORE,    32'd15,        12'h000, 1'b1, 32'h0000_0000);
        issue(ACT_SUB,      32'h0000_0001, 12'h000, 1'b1, 32'h0000_0000);
        issue(ACT_JGTZ,     32'h0000_0000, 12'hfff, 1'b1, 32'h0000_0000);
        issue(ACT_JGTZ,     32'h0000_0000, 12'h0aa, 1'b0, 32'h0000_0000);
        issue(ACT_MUL,      32'h7fff_ffff, 12'h000, 1'b1, 32'h0000_0000);
        // Direct load, in range and with bad indexes.
        issue(ACT_LOAD_DIR, 32'd15,        12'h000, 1'b1, 32'h0000_0000);
        issue(ACT_LOAD_DIR, 32'd16,        12'h000, 1'b1, 32'h0000_0000);
        issue(ACT_LOAD_DIR, 32'hffff_ffff, 12'h000, 1'b1, 32'h0000_0000);
        // Truncating division of a negative value, then division by zero.
        issue(ACT_LOAD_IMM, 32'hffff_fff9, 12'h000, 1'b1, 32'h0000_0000);
        issue(ACT_DIV,      32'h0000_0002, 12'h000, 1'b1, 32'h0000_0000);
        issue(ACT_DIV,      32'h0000_0000, 12'h000, 1'b1, 32'h0000_0000);
        // Tape traffic, good and bad indexes.
        issue(ACT_READ,     32'd3,         12'h000, 1'b1, 32'hffff_ffff);
        issue(ACT_READ,     32'h8000_0000, 12'h000, 1'b1, 32'h1234_5678);
        issue(ACT_WRITE,    32'd3,         12'h000, 1'b1, 32'h0000_0000);
        issue(ACT_WRITE,    32'd16,        12'h000, 1'b1, 32'h0000_0000);
        issue(ACT_STORE,    32'h8000_0000, 12'h000, 1'b1, 32'h0000_0000);
        // Unconditional jumps and the unused action codes.
        issue(ACT_JUMP,     32'h0000_0000, 12'hfff, 1'b1, 32'h0000_0000);
        issue(ACT_JUMP,     32'hffff_ffff, 12'h000, 1'b0, 32'h0000_0000);
        issue(ACT_SPARE_LO, 32'h0000_0000, 12'h000, 1'b0, 32'h0000_0000);
        issue(ACT_SPARE_HI, 32'hffff_ffff, 12'hfff, 1'b1, 32'hffff_ffff);

        // Random instructions, mostly well formed.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == 200) hold_requests++;
            if (n == 420) begin
                sender_gap(1);
                wait (outstanding == 0);
            end
            calm_phase = (n >= 550 && n < 650);
            if ($urandom_range(0, 99) < 4) act = 4'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
            else act = 4'($urandom_range(ACT_LOAD_IMM, ACT_JGTZ));
            case (act)
                ACT_LOAD_DIR, ACT_STORE, ACT_READ, ACT_WRITE: begin
                    if ($urandom_range(0, 99) < 85) operand = $urandom_range(0, NUM_REGS - 1);
                    else operand = pick_word();
                end
                default: operand = pick_word();
            endcase
            issue(act, operand, TGT_W'($urandom_range(0, PROG_DEPTH - 1)),
                  $urandom_range(0, 99) < 85, pick_word());
            if (!calm_phase) sender_gap(idle_length());
        end
        sender_gap(1);

        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk) end_of_test = 1'b1;
        repeat (2) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
